// ===== hdl/tccf_pkg.sv =====
// shared types and constants for the tcp client connection control block
// no dependencies; imported by every module of the block
package tccf_pkg;

    // input opcodes
    localparam logic [2:0] OP_SEGMENT    = 3'd0;
    localparam logic [2:0] OP_POLL       = 3'd1;
    localparam logic [2:0] OP_CONNECT    = 3'd2;
    localparam logic [2:0] OP_DISCONNECT = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;

    // classified command kinds
    localparam logic [2:0] CMD_NOP        = 3'd0;
    localparam logic [2:0] CMD_SEGMENT    = 3'd1;
    localparam logic [2:0] CMD_POLL       = 3'd2;
    localparam logic [2:0] CMD_CONNECT    = 3'd3;
    localparam logic [2:0] CMD_DISCONNECT = 3'd4;
    localparam logic [2:0] CMD_TICK       = 3'd5;

    // tcp flag patterns
    localparam logic [8:0] F_SYN    = 9'h002;
    localparam logic [8:0] F_ACK    = 9'h010;
    localparam logic [8:0] F_FINACK = 9'h011;
    localparam logic [8:0] F_SYNACK = 9'h012;

    // connection states
    localparam logic [2:0] ST_CLOSED     = 3'd0;
    localparam logic [2:0] ST_SYN_SENT   = 3'd1;
    localparam logic [2:0] ST_ESTAB      = 3'd2;
    localparam logic [2:0] ST_FIN1       = 3'd3;
    localparam logic [2:0] ST_FIN2       = 3'd4;
    localparam logic [2:0] ST_CLOSE_WAIT = 3'd5;
    localparam logic [2:0] ST_LAST_ACK   = 3'd6;
    localparam logic [2:0] ST_TIME_WAIT  = 3'd7;

    localparam logic [15:0] TW_TICKS_RESET = 16'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [8:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [31:0] initial_seq;
    } t_item;

    typedef struct packed {
        logic        send_valid;
        logic [8:0]  send_flags;
        logic [31:0] send_seq;
        logic [31:0] send_ack;
        logic [2:0]  conn_state;
        logic        wait_timer_running;
    } t_result;

    typedef struct packed {
        logic [2:0]  kind;
        logic        is_synack;
        logic        is_finack;
        logic        is_ack;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [31:0] initial_seq;
    } t_cmd;

endpackage

// ===== hdl/tccf_front.sv =====
// front stage: accepts events, decodes the opcode and matches segment flags
// depends on tccf_pkg; feeds tccf_queue through a one-entry register
module tccf_front
    import tccf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_item i_in_item,
    output logic  o_cmd_valid,
    input  logic  i_cmd_stall,
    output t_cmd  o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_take;

    // no transfer is taken while reset is held
    assign o_in_stall  = !i_rst_n || (r_valid && i_cmd_stall);
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd             = r_cmd;
        n_valid           = r_valid && i_cmd_stall;
        if (w_take) begin
            n_valid           = 1'b1;
            n_cmd.is_synack   = (i_in_item.seg_flags == F_SYNACK);
            n_cmd.is_finack   = (i_in_item.seg_flags == F_FINACK);
            n_cmd.is_ack      = (i_in_item.seg_flags == F_ACK);
            n_cmd.seg_seq     = i_in_item.seg_seq;
            n_cmd.seg_ack     = i_in_item.seg_ack;
            n_cmd.initial_seq = i_in_item.initial_seq;
            case (i_in_item.opcode)
                OP_SEGMENT:    n_cmd.kind = CMD_SEGMENT;
                OP_POLL:       n_cmd.kind = CMD_POLL;
                OP_CONNECT:    n_cmd.kind = CMD_CONNECT;
                OP_DISCONNECT: n_cmd.kind = CMD_DISCONNECT;
                OP_TICK:       n_cmd.kind = CMD_TICK;
                default:       n_cmd.kind = CMD_NOP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// ===== hdl/tccf_queue.sv =====
// short command queue between the front and back stages
// depends on tccf_pkg for the command type
module tccf_queue
    import tccf_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_stall,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_stall,
    output t_cmd o_pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_stall = (r_count == CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && !o_push_stall;
    assign w_pop        = o_pop_valid && !i_pop_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== hdl/tccf_back.sv =====
// back stage: connection state machine, time-wait countdown and result register
// depends on tccf_pkg; pops commands from tccf_queue
module tccf_back
    import tccf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic        i_cmd_valid,
    output logic        o_cmd_stall,
    input  t_cmd        i_cmd,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_result
);

    logic [15:0] r_time_wait_ticks;
    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic        r_connect_pending;
    logic        n_connect_pending;
    logic        r_disconnect_pending;
    logic        n_disconnect_pending;
    logic        r_synack_seen;
    logic        n_synack_seen;
    logic        r_finack_seen;
    logic        n_finack_seen;
    logic        r_ack_seen;
    logic        n_ack_seen;
    logic        r_timer_active;
    logic        n_timer_active;
    logic [15:0] r_timer_count;
    logic [15:0] n_timer_count;
    logic [31:0] r_peer_seq;
    logic [31:0] n_peer_seq;
    logic [31:0] r_peer_ack;
    logic [31:0] n_peer_ack;
    logic        r_out_valid;
    logic        n_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        w_pop;
    logic        w_reply;
    logic [8:0]  w_reply_flags;
    logic [31:0] w_reply_ack;

    assign o_cmd_stall  = r_out_valid && i_out_stall;
    assign w_pop        = i_cmd_valid && !o_cmd_stall;
    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;
    assign w_reply_ack  = r_peer_seq + 32'd1;

    always_comb begin
        n_state              = r_state;
        n_connect_pending    = r_connect_pending;
        n_disconnect_pending = r_disconnect_pending;
        n_synack_seen        = r_synack_seen;
        n_finack_seen        = r_finack_seen;
        n_ack_seen           = r_ack_seen;
        n_timer_active       = r_timer_active;
        n_timer_count        = r_timer_count;
        n_peer_seq           = r_peer_seq;
        n_peer_ack           = r_peer_ack;
        n_out_valid          = r_out_valid && i_out_stall;
        n_out                = r_out;
        w_reply              = 1'b0;
        w_reply_flags        = F_ACK;

        if (w_pop) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            case (i_cmd.kind)
                CMD_SEGMENT: begin
                    if (i_cmd.is_synack) n_synack_seen = 1'b1;
                    if (i_cmd.is_finack) n_finack_seen = 1'b1;
                    if (i_cmd.is_ack)    n_ack_seen    = 1'b1;
                    n_peer_seq = i_cmd.seg_seq;
                    n_peer_ack = i_cmd.seg_ack;
                end
                CMD_POLL: begin
                    case (r_state)
                        ST_CLOSED: begin
                            if (r_connect_pending) begin
                                n_connect_pending = 1'b0;
                                n_out.send_valid  = 1'b1;
                                n_out.send_flags  = F_SYN;
                                n_out.send_seq    = i_cmd.initial_seq;
                                n_peer_seq        = i_cmd.initial_seq;
                                n_peer_ack        = 32'd1;
                                n_state           = ST_SYN_SENT;
                            end
                        end
                        ST_SYN_SENT: begin
                            if (r_synack_seen) begin
                                n_synack_seen = 1'b0;
                                w_reply       = 1'b1;
                                n_state       = ST_ESTAB;
                            end
                        end
                        ST_ESTAB: begin
                            // a local close request wins over a peer close
                            if (r_disconnect_pending) begin
                                n_disconnect_pending = 1'b0;
                                w_reply              = 1'b1;
                                w_reply_flags        = F_FINACK;
                                n_state              = ST_FIN1;
                            end else if (r_finack_seen) begin
                                n_finack_seen = 1'b0;
                                w_reply       = 1'b1;
                                n_state       = ST_CLOSE_WAIT;
                            end
                        end
                        ST_CLOSE_WAIT: begin
                            w_reply       = 1'b1;
                            w_reply_flags = F_FINACK;
                            n_state       = ST_LAST_ACK;
                        end
                        ST_LAST_ACK: begin
                            if (r_ack_seen) begin
                                n_ack_seen = 1'b0;
                                n_state    = ST_CLOSED;
                            end
                        end
                        ST_FIN1: begin
                            if (r_ack_seen) begin
                                n_ack_seen = 1'b0;
                                n_state    = ST_FIN2;
                            end
                        end
                        ST_FIN2: begin
                            if (r_finack_seen) begin
                                n_finack_seen = 1'b0;
                                w_reply       = 1'b1;
                                n_state       = ST_TIME_WAIT;
                            end
                        end
                        default: begin
                            if (!r_timer_active) begin
                                n_timer_active = 1'b1;
                                n_timer_count  = r_time_wait_ticks;
                            end
                        end
                    endcase
                end
                CMD_CONNECT:    n_connect_pending    = 1'b1;
                CMD_DISCONNECT: n_disconnect_pending = 1'b1;
                CMD_TICK: begin
                    if (r_timer_active) begin
                        // a count of zero or one ends time-wait
                        if (r_timer_count <= 16'd1) begin
                            n_timer_count  = '0;
                            n_timer_active = 1'b0;
                            n_state        = ST_CLOSED;
                        end else begin
                            n_timer_count = r_timer_count - 16'd1;
                        end
                    end
                end
                default: ;
            endcase
            if (w_reply) begin
                n_out.send_valid = 1'b1;
                n_out.send_flags = w_reply_flags;
                n_out.send_seq   = r_peer_ack;
                n_out.send_ack   = w_reply_ack;
            end
            n_out.conn_state         = n_state;
            n_out.wait_timer_running = n_timer_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_wait_ticks    <= TW_TICKS_RESET;
            r_state              <= ST_CLOSED;
            r_connect_pending    <= 1'b1;
            r_disconnect_pending <= 1'b0;
            r_synack_seen        <= 1'b0;
            r_finack_seen        <= 1'b0;
            r_ack_seen           <= 1'b0;
            r_timer_active       <= 1'b0;
            r_timer_count        <= '0;
            r_peer_seq           <= '0;
            r_peer_ack           <= '0;
            r_out_valid          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_time_wait_ticks <= i_cfg_data;
            end
            r_state              <= n_state;
            r_connect_pending    <= n_connect_pending;
            r_disconnect_pending <= n_disconnect_pending;
            r_synack_seen        <= n_synack_seen;
            r_finack_seen        <= n_finack_seen;
            r_ack_seen           <= n_ack_seen;
            r_timer_active       <= n_timer_active;
            r_timer_count        <= n_timer_count;
            r_peer_seq           <= n_peer_seq;
            r_peer_ack           <= n_peer_ack;
            r_out_valid          <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule

// ===== hdl/tcp_client_connection_fsm_unit.sv =====
// top level of the tcp client connection control block
// depends on tccf_pkg, tccf_front, tccf_queue and tccf_back
//
// channel   direction  handshake               payload
// in        input      i_in_valid / o_in_stall   i_in_item (t_item)
// out       output     o_out_valid / i_out_stall o_out_result (t_result)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (time_wait_ticks)
//
// one event per cycle sustained while the output is not stalled; an input transfer
// reaches the result through the front decode register, queue entry and back result register
// the back state machine handles one command per cycle while the output is not stalled,
// set by its single update of the connection registers
// synchronous active-low reset clears control state, sets a connect request pending and time_wait_ticks to 3
// a stall on the output backs up the queue; the input stalls once it and the front register are full
module tcp_client_connection_fsm_unit
    import tccf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_item       i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic w_front_valid;
    logic w_front_stall;
    t_cmd w_front_cmd;
    logic w_back_valid;
    logic w_back_stall;
    t_cmd w_back_cmd;

    assign o_cfg_ready = i_rst_n;

    tccf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_front_valid),
        .i_cmd_stall (w_front_stall),
        .o_cmd       (w_front_cmd)
    );

    tccf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_stall (w_front_stall),
        .i_push_cmd   (w_front_cmd),
        .o_pop_valid  (w_back_valid),
        .i_pop_stall  (w_back_stall),
        .o_pop_cmd    (w_back_cmd)
    );

    tccf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (w_back_valid),
        .o_cmd_stall  (w_back_stall),
        .i_cmd        (w_back_cmd),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the tcp client connection control block
// depends on tccf_pkg and tcp_client_connection_fsm_unit; predicts every result in-line
// directed open/close sequences, then random sessions under several time-wait settings
module tb
    import tccf_pkg::*;
();

    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          IDLE_PCT       = 27;
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_item       i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_result     o_out_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    // predicted connection state
    logic [2:0]  m_state;
    logic        m_connect_req;
    logic        m_disconnect_req;
    logic        m_synack;
    logic        m_finack;
    logic        m_ack;
    logic        m_timer_on;
    logic [15:0] m_timer_left;
    logic [31:0] m_peer_seq;
    logic [31:0] m_peer_ack;
    logic [15:0] m_wait_ticks;

    t_result expected_replies [$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      sender_gaps = 1'b1;
    bit      receiver_quiet = 1'b0;

    tcp_client_connection_fsm_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= receiver_quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    function automatic void reset_model();
        m_state          = ST_CLOSED;
        m_connect_req    = 1'b1;
        m_disconnect_req = 1'b0;
        m_synack         = 1'b0;
        m_finack         = 1'b0;
        m_ack            = 1'b0;
        m_timer_on       = 1'b0;
        m_timer_left     = '0;
        m_peer_seq       = '0;
        m_peer_ack       = '0;
        m_wait_ticks     = TW_TICKS_RESET;
    endfunction

    // one of the three flag patterns that the block matches
    function automatic logic [8:0] match_flags(input int k);
        case (k)
            0:       return F_SYNACK;
            1:       return F_FINACK;
            default: return F_ACK;
        endcase
    endfunction

    // outgoing ack or fin/ack answers from the captured peer numbers
    function automatic void load_reply(inout t_result r, input logic [8:0] flags);
        r.send_valid = 1'b1;
        r.send_flags = flags;
        r.send_seq   = m_peer_ack;
        r.send_ack   = m_peer_seq + 32'd1;
    endfunction

    function automatic t_result conn_model_step(input t_item ev);
        t_result r;
        r = '0;
        case (ev.opcode)
            OP_SEGMENT: begin
                if (ev.seg_flags == F_SYNACK) m_synack = 1'b1;
                if (ev.seg_flags == F_FINACK) m_finack = 1'b1;
                if (ev.seg_flags == F_ACK) m_ack = 1'b1;
                m_peer_seq = ev.seg_seq;
                m_peer_ack = ev.seg_ack;
            end
            OP_POLL: begin
                case (m_state)
                    ST_CLOSED: if (m_connect_req) begin
                        m_connect_req = 1'b0;
                        r.send_valid  = 1'b1;
                        r.send_flags  = F_SYN;
                        r.send_seq    = ev.initial_seq;
                        r.send_ack    = '0;
                        m_peer_seq    = ev.initial_seq;
                        m_peer_ack    = 32'd1;
                        m_state       = ST_SYN_SENT;
                    end
                    ST_SYN_SENT: if (m_synack) begin
                        m_synack = 1'b0;
                        load_reply(r, F_ACK);
                        m_state = ST_ESTAB;
                    end
                    ST_ESTAB: begin
                        // our own close request wins over a peer fin
                        if (m_disconnect_req) begin
                            m_disconnect_req = 1'b0;
                            load_reply(r, F_FINACK);
                            m_state = ST_FIN1;
                        end else if (m_finack) begin
                            m_finack = 1'b0;
                            load_reply(r, F_ACK);
                            m_state = ST_CLOSE_WAIT;
                        end
                    end
                    ST_CLOSE_WAIT: begin
                        load_reply(r, F_FINACK);
                        m_state = ST_LAST_ACK;
                    end
                    ST_LAST_ACK: if (m_ack) begin
                        m_ack   = 1'b0;
                        m_state = ST_CLOSED;
                    end
                    ST_FIN1: if (m_ack) begin
                        m_ack   = 1'b0;
                        m_state = ST_FIN2;
                    end
                    ST_FIN2: if (m_finack) begin
                        m_finack = 1'b0;
                        load_reply(r, F_ACK);
                        m_state = ST_TIME_WAIT;
                    end
                    default: if (!m_timer_on) begin
                        m_timer_on   = 1'b1;
                        m_timer_left = m_wait_ticks;
                    end
                endcase
            end
            OP_CONNECT:    m_connect_req = 1'b1;
            OP_DISCONNECT: m_disconnect_req = 1'b1;
            OP_TICK: begin
                if (m_timer_on) begin
                    if (m_timer_left <= 16'd1) begin
                        m_timer_left = '0;
                        m_timer_on   = 1'b0;
                        m_state      = ST_CLOSED;
                    end else begin
                        m_timer_left = m_timer_left - 16'd1;
                    end
                end
            end
            default: ;
        endcase
        r.conn_state         = m_state;
        r.wait_timer_running = m_timer_on;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item make_event(input logic [2:0] op, input logic [8:0] flags,
                                         input logic [31:0] seq, input logic [31:0] ack,
                                         input logic [31:0] iss);
        t_item ev;
        ev.opcode      = op;
        ev.seg_flags   = flags;
        ev.seg_seq     = seq;
        ev.seg_ack     = ack;
        ev.initial_seq = iss;
        return ev;
    endfunction

    // mostly the event that moves the connection on from its present state
    function automatic t_item next_event(input int noise_pct);
        t_item ev;
        ev = make_event(OP_POLL, 9'($urandom), rand_word(), rand_word(), rand_word());
        if ($urandom_range(99) < noise_pct) begin
            ev.opcode = 3'($urandom_range(7));
            if ($urandom_range(1))
                ev.seg_flags = match_flags($urandom_range(2)) ^ (9'd1 << $urandom_range(8));
            return ev;
        end
        case (m_state)
            ST_CLOSED: if (!m_connect_req) ev.opcode = OP_CONNECT;
            ST_SYN_SENT: if (!m_synack) begin
                ev.opcode    = OP_SEGMENT;
                ev.seg_flags = F_SYNACK;
            end
            ST_ESTAB: if (!m_disconnect_req && !m_finack) begin
                case ($urandom_range(3))
                    0: ev.opcode = OP_DISCONNECT;
                    1: begin
                        ev.opcode    = OP_SEGMENT;
                        ev.seg_flags = F_FINACK;
                    end
                    2: ev.opcode = OP_POLL;
                    default: begin
                        ev.opcode    = OP_SEGMENT;
                        ev.seg_flags = match_flags($urandom_range(2));
                    end
                endcase
            end
            ST_FIN1, ST_LAST_ACK: if (!m_ack) begin
                ev.opcode    = OP_SEGMENT;
                ev.seg_flags = F_ACK;
            end
            ST_FIN2: if (!m_finack) begin
                ev.opcode    = OP_SEGMENT;
                ev.seg_flags = F_FINACK;
            end
            ST_TIME_WAIT: if (m_timer_on) ev.opcode = OP_TICK;
            default: ;
        endcase
        return ev;
    endfunction

    // one input transfer; valid stays up on return so the next call can follow at once
    task automatic send_event(input t_item ev);
        while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        expected_replies.push_back(conn_model_step(ev));
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_wait_ticks(input logic [15:0] ticks);
        drain_replies();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        m_wait_ticks = ticks;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_sessions(input int count, input int noise_pct);
        for (int n = 0; n < count; n++) send_event(next_event(noise_pct));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result transfer %p", o_out_result);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                check_field("send_valid", 32'(want.send_valid),
                            32'(o_out_result.send_valid));
                check_field("send_flags", 32'(want.send_flags),
                            32'(o_out_result.send_flags));
                check_field("send_seq", want.send_seq, o_out_result.send_seq);
                check_field("send_ack", want.send_ack, o_out_result.send_ack);
                check_field("conn_state", 32'(want.conn_state),
                            32'(o_out_result.conn_state));
                check_field("wait_timer_running", 32'(want.wait_timer_running),
                            32'(o_out_result.wait_timer_running));
            end
        end
    end

    // open, close from our side, run out time-wait at the reset tick count
    task automatic test_active_close();
        send_event(make_event(OP_POLL, '0, '0, '0, '1));
        send_event(make_event(OP_POLL, '1, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_SEGMENT, F_SYNACK, '1, '0, '1));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_DISCONNECT, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_SEGMENT, F_FINACK, 32'h1234_5678, 32'h9abc_def0, '0));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_SEGMENT, F_ACK, 32'h0000_0001, 32'hffff_fffe, '0));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        // fin latched while established is still pending here
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        repeat (4) send_event(make_event(OP_TICK, '0, rand_word(), rand_word(), rand_word()));
        for (int k = 0; k < 3; k++)
            send_event(make_event(OP_SPARE_FIRST + 3'(k), '1, '1, '1, '1));
    endtask

    // peer closes first; unmatched flags are only latched as numbers
    task automatic test_passive_close();
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_CONNECT, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_POLL, '0, '1, '1, '0));
        send_event(make_event(OP_SEGMENT, '1, '1, '1, '0));
        send_event(make_event(OP_SEGMENT, F_SYNACK, '0, '1, '0));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_SEGMENT, F_FINACK, 32'h8000_0000, 32'h7fff_ffff, '1));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_SEGMENT, F_ACK, rand_word(), rand_word(), rand_word()));
        send_event(make_event(OP_POLL, '0, rand_word(), rand_word(), rand_word()));
    endtask

    task automatic test_short_time_wait();
        write_wait_ticks(16'd1);
        run_sessions(300, 20);
    endtask

    // full countdown at a long setting, back to back on both sides
    task automatic test_long_time_wait();
        bit waited;
        waited = 1'b0;
        write_wait_ticks(16'd60);
        sender_gaps    = 1'b0;
        receiver_quiet = 1'b1;
        while (!(waited && m_state == ST_CLOSED)) begin
            send_event(next_event(0));
            if (m_state == ST_TIME_WAIT && m_timer_on) waited = 1'b1;
        end
        sender_gaps    = 1'b1;
        receiver_quiet = 1'b0;
    endtask

    task automatic test_random_sessions();
        write_wait_ticks(16'd2);
        run_sessions(350, 25);
        write_wait_ticks(16'($urandom_range(4, 40)));
        run_sessions(350, 30);
        write_wait_ticks(TW_TICKS_RESET);
        run_sessions(350, 25);
    endtask

    initial begin
        reset_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_active_close();
        test_passive_close();
        test_short_time_wait();
        test_long_time_wait();
        test_random_sessions();
        drain_replies();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
